/* sv/mhec_pkg.sv */
// Package for the multichannel hysteresis and EMA conditioner.
// Holds sizes, fixed-point constants, register map and shared types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mhec_pkg;

    localparam int CHANNELS    = 8;
    localparam int CH_IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CHAN_W      = 3;
    localparam int RAW_W       = 12;
    localparam int MV_W        = 13;
    localparam int CFG_W       = 12;
    localparam int PROD_W      = 2 * RAW_W;
    localparam int VQ8_W       = 21;
    localparam int SCALED_W    = PROD_W + 13;
    localparam int MIX_W       = 30;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int PADDR_W     = 4;
    localparam int PDATA_W     = 32;

    localparam logic [12:0]     SCALE_NUM = 13'd7520;
    localparam logic [6:0]      ALPHA_NEW = 7'd77;
    localparam logic [7:0]      ALPHA_OLD = 8'd179;
    localparam logic [MV_W-1:0] MV_MAX    = 13'd8191;

    localparam logic [CFG_W-1:0] HIGH_RESET   = 12'd2500;
    localparam logic [CFG_W-1:0] LOW_RESET    = 12'd1500;
    localparam logic [CFG_W-1:0] SUPPLY_RESET = 12'd3300;

    localparam logic [1:0] REG_HIGH   = 2'd0;
    localparam logic [1:0] REG_LOW    = 2'd1;
    localparam logic [1:0] REG_SUPPLY = 2'd2;

    typedef struct packed {
        logic [CFG_W-1:0] high_threshold;
        logic [CFG_W-1:0] low_threshold;
        logic [CFG_W-1:0] supply_mv;
    } t_cfg;

    typedef struct packed {
        logic [CHAN_W-1:0] channel;
        logic [RAW_W-1:0]  raw_sample;
        logic              in_range;
        logic [PROD_W-1:0] product;
    } t_work;

    typedef struct packed {
        logic full;
        logic valid;
    } t_qstat;

endpackage

`default_nettype wire

/* sv/mhec_ifs.sv */
// Handshake channels for the conditioner: sample input and result output.
// Depends on mhec_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface mhec_in_if import mhec_pkg::*;;
    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] channel;
    logic [RAW_W-1:0]  raw_sample;

    modport source (output valid, output channel, output raw_sample, input ready);
    modport sink   (input valid, input channel, input raw_sample, output ready);
endinterface

interface mhec_out_if import mhec_pkg::*;;
    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] out_channel;
    logic              digital_level;
    logic [RAW_W-1:0]  raw_echo;
    logic [MV_W-1:0]   filtered_mv;

    modport source (output valid, output out_channel, output digital_level,
                    output raw_echo, output filtered_mv, input ready);
    modport sink   (input valid, input out_channel, input digital_level,
                    input raw_echo, input filtered_mv, output ready);
endinterface

`default_nettype wire

/* sv/mhec_front.sv */
// Front end: accepts samples, checks the channel and forms raw * supply.
// Depends on mhec_pkg and mhec_ifs.
`timescale 1ns / 1ps
`default_nettype none

module mhec_front import mhec_pkg::*; (
    mhec_in_if.sink          i_in,
    input  wire t_cfg        i_cfg,
    input  wire t_qstat      i_qstat,
    output logic             o_push,
    output t_work            o_work
);

    assign i_in.ready = !i_qstat.full;
    assign o_push     = i_in.valid && !i_qstat.full;

    always_comb begin
        o_work.channel    = i_in.channel;
        o_work.raw_sample = i_in.raw_sample;
        o_work.in_range   = (32'(i_in.channel) < 32'(CHANNELS));
        o_work.product    = PROD_W'({12'd0, i_in.raw_sample} * {12'd0, i_cfg.supply_mv});
    end

endmodule

`default_nettype wire

/* sv/mhec_queue.sv */
// Short FIFO of classified work between the front and the back end.
// Depends on mhec_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mhec_queue import mhec_pkg::*; (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_push,
    input  wire t_work  i_work,
    input  wire         i_pop,
    output t_qstat      o_qstat,
    output t_work       o_head
);

    t_work             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_count;
    logic [QPTR_W-1:0] n_wr;
    logic [QPTR_W-1:0] n_rd;
    logic              do_push;
    logic              do_pop;

    assign o_qstat.full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_qstat.valid = (r_count != '0);
    assign o_head        = r_mem[r_rd];
    assign do_push       = i_push && !o_qstat.full;
    assign do_pop        = i_pop && o_qstat.valid;

    always_comb begin
        n_wr = (r_wr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        n_rd = (r_rd == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_work;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= n_wr;
            end
            if (do_pop) begin
                r_rd <= n_rd;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

/* sv/mhec_back.sv */
// Back end: per-channel hysteresis and EMA read-modify-write, result register.
// Depends on mhec_pkg and mhec_ifs.
`timescale 1ns / 1ps
`default_nettype none

module mhec_back import mhec_pkg::*; (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire t_cfg    i_cfg,
    input  wire t_qstat  i_qstat,
    input  wire t_work   i_head,
    output logic         o_pop,
    mhec_out_if.source   o_out
);

    typedef enum logic {
        S_SCALE,
        S_MIX
    } t_state;

    t_state               r_state;
    logic                 r_lvl [CHANNELS];
    logic [MV_W-1:0]      r_avg [CHANNELS];
    logic [VQ8_W-1:0]     r_v;
    logic [MV_W-1:0]      r_old;
    logic                 r_level;
    logic [CHAN_W-1:0]    r_ch;
    logic [RAW_W-1:0]     r_raw;
    logic                 r_ok;
    logic [CH_IDX_W-1:0]  r_idx;
    logic                 r_out_valid;
    logic [CHAN_W-1:0]    r_out_ch;
    logic                 r_out_level;
    logic [RAW_W-1:0]     r_out_raw;
    logic [MV_W-1:0]      r_out_mv;

    logic [CH_IDX_W-1:0]  idx;
    logic                 old_lvl;
    logic                 n_level;
    logic [SCALED_W-1:0]  scaled;
    logic [VQ8_W-1:0]     n_v;
    logic [MIX_W-1:0]     mix;
    logic [MIX_W-16-1:0]  mix_mv;
    logic [MV_W-1:0]      n_mv;
    logic                 out_free;
    logic                 load;

    always_comb begin
        idx     = CH_IDX_W'(i_head.channel);
        old_lvl = r_lvl[idx];
        if (i_head.raw_sample > i_cfg.high_threshold) begin
            n_level = 1'b1;
        end else if (i_head.raw_sample < i_cfg.low_threshold) begin
            n_level = 1'b0;
        end else begin
            n_level = old_lvl;
        end
        n_level = n_level && i_head.in_range;
        scaled  = SCALED_W'(i_head.product) * SCALED_W'(SCALE_NUM);
        n_v     = scaled[SCALED_W-1:16];

        mix    = MIX_W'(MIX_W'(r_v) * MIX_W'(ALPHA_NEW))
               + MIX_W'(MIX_W'({r_old, 8'd0}) * MIX_W'(ALPHA_OLD));
        mix_mv = mix[MIX_W-1:16];
        n_mv   = (mix_mv > (MIX_W-16)'(MV_MAX)) ? MV_MAX : mix_mv[MV_W-1:0];
        if (!r_ok) begin
            n_mv = '0;
        end

        o_pop    = (r_state == S_SCALE) && i_qstat.valid;
        out_free = !r_out_valid || o_out.ready;
        load     = (r_state == S_MIX) && out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_SCALE;
            r_out_valid <= 1'b0;
            for (int i = 0; i < CHANNELS; i++) begin
                r_lvl[i] <= 1'b0;
                r_avg[i] <= '0;
            end
        end else begin
            case (r_state)
                S_SCALE: begin
                    if (i_qstat.valid) begin
                        r_v     <= n_v;
                        r_old   <= r_avg[idx];
                        r_level <= n_level;
                        r_ch    <= i_head.channel;
                        r_raw   <= i_head.raw_sample;
                        r_ok    <= i_head.in_range;
                        r_idx   <= idx;
                        r_state <= S_MIX;
                    end
                end
                S_MIX: begin
                    if (out_free) begin
                        r_out_ch    <= r_ch;
                        r_out_level <= r_level;
                        r_out_raw   <= r_raw;
                        r_out_mv    <= n_mv;
                        if (r_ok) begin
                            r_lvl[r_idx] <= r_level;
                            r_avg[r_idx] <= n_mv;
                        end
                        r_state <= S_SCALE;
                    end
                end
                default: r_state <= S_SCALE;
            endcase
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.out_channel   = r_out_ch;
    assign o_out.digital_level = r_out_level;
    assign o_out.raw_echo      = r_out_raw;
    assign o_out.filtered_mv   = r_out_mv;

    a_pop_in_scale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_state == S_MIX)
        else $error("pop did not advance to mix step");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |-> (!r_out_valid || o_out.ready))
        else $error("result register overwritten while stalled");

    a_store_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && r_ok) |=> (r_avg[$past(r_idx)] == r_out_mv
                            && r_lvl[$past(r_idx)] == r_out_level))
        else $error("channel store disagrees with delivered result");

    a_range_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && !r_ok) |=> (r_out_mv == '0 && r_out_level == 1'b0))
        else $error("out-of-range channel gave nonzero result");

endmodule

`default_nettype wire

/* sv/multichannel_hysteresis_ema_conditioner_top.sv */
// A sample passes the two-entry queue, then the back end's two-step
// per-channel read-modify-write (scale, then mix and write back), which
// takes no new sample until the last is written to the result register.
// The input stays ready while the two-entry queue has room, also under stall.
// Reset (synchronous, active low): thresholds 2500/1500, supply 3300 mV,
// all channel levels and averages zero, queue and result register empty.
`timescale 1ns / 1ps
`default_nettype none

module multichannel_hysteresis_ema_conditioner_top import mhec_pkg::*; (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    mhec_in_if.sink             i_in,
    mhec_out_if.source          o_out,
    input  wire                 psel,
    input  wire                 penable,
    input  wire                 pwrite,
    input  wire [PADDR_W-1:0]   paddr,
    input  wire [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready
);

    t_cfg   r_cfg;
    t_qstat qstat;
    t_work  push_work;
    t_work  head;
    logic   push;
    logic   pop;
    logic   wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.high_threshold <= HIGH_RESET;
            r_cfg.low_threshold  <= LOW_RESET;
            r_cfg.supply_mv      <= SUPPLY_RESET;
        end else if (wr_en) begin
            case (paddr[3:2])
                REG_HIGH:   r_cfg.high_threshold <= pwdata[CFG_W-1:0];
                REG_LOW:    r_cfg.low_threshold  <= pwdata[CFG_W-1:0];
                REG_SUPPLY: r_cfg.supply_mv      <= pwdata[CFG_W-1:0];
                default:    r_cfg <= r_cfg;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_HIGH:   prdata = PDATA_W'(r_cfg.high_threshold);
            REG_LOW:    prdata = PDATA_W'(r_cfg.low_threshold);
            REG_SUPPLY: prdata = PDATA_W'(r_cfg.supply_mv);
            default:    prdata = '0;
        endcase
    end

    mhec_front u_front (
        .i_in    (i_in),
        .i_cfg   (r_cfg),
        .i_qstat (qstat),
        .o_push  (push),
        .o_work  (push_work)
    );

    mhec_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_work  (push_work),
        .i_pop   (pop),
        .o_qstat (qstat),
        .o_head  (head)
    );

    mhec_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_qstat (qstat),
        .i_head  (head),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire
